>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the cache lookup checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clk edge outside reset
`define DSC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every clk edge, reset included
`define DSC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and codes for the decoupled sectored cache lookup
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int ADDR_W   = 32;
	localparam int ACTION_W = 1;
	localparam int WB_W     = 3;

	localparam logic [ACTION_W-1:0] ACT_READ  = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 1'b1;

	localparam logic [1:0] KIND_HIT        = 2'd0;
	localparam logic [1:0] KIND_MISS_EMPTY = 2'd1;
	localparam logic [1:0] KIND_MISS_OCC   = 2'd2;
	localparam logic [1:0] KIND_RESERVED   = 2'd3;

	localparam logic [WB_W-1:0] WB_MAX = 3'd7;

	// result transaction, hit in bit 0
	typedef struct packed {
		logic            pad;
		logic [WB_W-1:0] writebacks;
		logic            tag_replaced;
		logic [1:0]      miss_kind;
		logic            hit;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

>>> design/dsc_ram.sv
// ----------------------------------------------------------------------------
// dsc_ram
// Simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module dsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/decoupled_sector_cache_lookup.sv
// ----------------------------------------------------------------------------
// decoupled_sector_cache_lookup
// Direct-mapped decoupled sectored cache: tag/state lookup and update
//
// Request channel s_*: one access per transaction, address in s_tdata,
// read/write in s_tuser. Result channel m_*: hit, miss kind, tag replaced
// flag and writeback count in m_tdata.
// An access reads its set's tag row and block row once, evaluates, and
// writes both rows back: it passes S_READ, S_EVAL and S_FINAL, and m_tvalid
// rises as it leaves S_FINAL; when a tag is replaced an S_SCAN sweep over the
// set's blocks, one selector compare per cycle, comes before S_FINAL. One access is in
// flight at a time; s_tready is high only while idle, so a new access is taken
// only once the last one has written back and left S_FINAL.
// After reset a clearing pass zeroes both memories, one set per cycle,
// through all SET_COUNT sets, with s_tready low.
// The result sits in an output register; while m_tready is low the next
// access is still taken and worked, and holds before its write-back until
// the register frees.
// ----------------------------------------------------------------------------
module decoupled_sector_cache_lookup
	import dsc_pkg::*;
#(
	parameter int SET_COUNT    = 64,
	parameter int DATA_BLOCKS  = 4,
	parameter int ADDRESS_TAGS = 8,
	parameter int BLOCK_BYTES  = 32,
	parameter int ADDR_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ADDR_W-1:0]   s_tdata,  // address[31:0]
	input  logic [ACTION_W-1:0] s_tuser,  // action
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [RESULT_W-1:0] m_tdata   // hit, miss_kind[1:0], tag_replaced,
	                                      // writebacks[2:0], zero pad
);

	localparam int OB   = $clog2(BLOCK_BYTES);
	localparam int DBB  = $clog2(DATA_BLOCKS);
	localparam int IB   = $clog2(SET_COUNT);
	localparam int TB   = $clog2(ADDRESS_TAGS);
	localparam int SH   = OB + DBB + IB + TB;
	localparam int AW   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int TAG_BITS = (AW > SH) ? AW - SH : 0;
	localparam int TAG_W  = (TAG_BITS > 0) ? TAG_BITS : 1;
	localparam int BLK_W  = (DBB > 0) ? DBB : 1;
	localparam int SET_W  = (IB > 0) ? IB : 1;
	localparam int SLOT_W = (TB > 0) ? TB : 1;
	localparam int BE     = SLOT_W + 2;
	localparam int WBC_W  = $clog2(DATA_BLOCKS + 2);
	localparam int TROW_W = ADDRESS_TAGS * TAG_W;
	localparam int BROW_W = DATA_BLOCKS * BE;

	localparam logic [ADDR_W-1:0] AMASK =
		(AW >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << AW) - 64'd1);
	localparam logic [ADDR_W-1:0] BLK_MASK  = ADDR_W'((64'd1 << DBB) - 64'd1);
	localparam logic [ADDR_W-1:0] SET_MASK  = ADDR_W'((64'd1 << IB) - 64'd1);
	localparam logic [ADDR_W-1:0] SLOT_MASK = ADDR_W'((64'd1 << TB) - 64'd1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_SCAN,
		S_FINAL
	} state_t;

	typedef enum logic [1:0] {
		M_HIT,
		M_FILL,
		M_REPL
	} mode_t;

	state_t              state_q;
	logic [SET_W-1:0]    clr_q;
	logic [BLK_W-1:0]    k_q;
	logic                m_valid_q;
	result_t             out_q;

	logic                wr_q;
	logic [BLK_W-1:0]    blk_q;
	logic [SET_W-1:0]    set_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [TAG_W-1:0]    tag_q;
	logic [DATA_BLOCKS-1:0] vld_q;
	logic [DATA_BLOCKS-1:0] drt_q;
	logic [SLOT_W-1:0]   sel_q [DATA_BLOCKS];
	mode_t               mode_q;
	logic [1:0]          kind_q;
	logic                repl_q;
	logic [WBC_W-1:0]    wb_q;

	logic [ADDR_W-1:0]   addr_m;
	logic [ADDR_W-1:0]   blk_f;
	logic [ADDR_W-1:0]   set_f;
	logic [ADDR_W-1:0]   slot_f;
	logic [ADDR_W-1:0]   blk_r;
	logic [ADDR_W-1:0]   set_r;
	logic [ADDR_W-1:0]   slot_r;

	logic [TROW_W-1:0]   trow;
	logic [BROW_W-1:0]   brow;
	logic [TAG_W-1:0]    trow_a [ADDRESS_TAGS];
	logic [DATA_BLOCKS-1:0] row_vld;
	logic [DATA_BLOCKS-1:0] row_drt;
	logic [SLOT_W-1:0]   row_sel [DATA_BLOCKS];
	logic                tag_eq;
	logic                hit_c;
	logic                any_c;

	logic [DATA_BLOCKS-1:0] nv;
	logic [DATA_BLOCKS-1:0] nd;
	logic [SLOT_W-1:0]   ns [DATA_BLOCKS];
	logic [TROW_W-1:0]   trow_new;
	logic [BROW_W-1:0]   brow_new;
	logic [WBC_W-1:0]    wb_sum;
	logic [WB_W-1:0]     wb_sat;
	logic                out_free;
	logic                fin_go;

	logic                ram_we;
	logic [SET_W-1:0]    ram_waddr;
	logic [TROW_W-1:0]   trow_wdata;
	logic [BROW_W-1:0]   brow_wdata;
	logic                ram_re;

	// address split, fields reduced modulo their counts
	always_comb begin
		addr_m = s_tdata & AMASK;
		blk_f  = (addr_m >> OB) & BLK_MASK;
		set_f  = (addr_m >> (OB + DBB)) & SET_MASK;
		slot_f = (addr_m >> (OB + DBB + IB)) & SLOT_MASK;
		blk_r  = (blk_f >= ADDR_W'(DATA_BLOCKS)) ? blk_f - ADDR_W'(DATA_BLOCKS) : blk_f;
		set_r  = (set_f >= ADDR_W'(SET_COUNT)) ? set_f - ADDR_W'(SET_COUNT) : set_f;
		slot_r = (slot_f >= ADDR_W'(ADDRESS_TAGS)) ?
			slot_f - ADDR_W'(ADDRESS_TAGS) : slot_f;
	end

	// row unpack and lookup
	always_comb begin
		for (int j = 0; j < ADDRESS_TAGS; j++) begin
			trow_a[j] = trow[j*TAG_W +: TAG_W];
		end
		for (int i = 0; i < DATA_BLOCKS; i++) begin
			row_vld[i] = brow[i*BE];
			row_drt[i] = brow[i*BE + 1];
			row_sel[i] = brow[i*BE + 2 +: SLOT_W];
		end
		tag_eq = (trow_a[slot_q] == tag_q);
		hit_c  = row_vld[blk_q] && tag_eq && (row_sel[blk_q] == slot_q);
		any_c  = |row_vld;
	end

	// write-back rows
	always_comb begin
		nv = vld_q;
		nd = drt_q;
		for (int i = 0; i < DATA_BLOCKS; i++) begin
			ns[i] = sel_q[i];
		end
		wb_sum = wb_q;
		case (mode_q)
			M_HIT: begin
				nd[blk_q] = drt_q[blk_q] | wr_q;
			end
			M_FILL: begin
				nv[blk_q] = 1'b1;
				nd[blk_q] = drt_q[blk_q] | wr_q;
				ns[blk_q] = slot_q;
			end
			M_REPL: begin
				nv[blk_q] = 1'b1;
				nd[blk_q] = wr_q;
				ns[blk_q] = slot_q;
				wb_sum    = wb_q + WBC_W'(drt_q[blk_q]);
			end
			default: begin
				nv = vld_q;
			end
		endcase
		for (int i = 0; i < DATA_BLOCKS; i++) begin
			brow_new[i*BE]            = nv[i];
			brow_new[i*BE + 1]        = nd[i];
			brow_new[i*BE + 2 +: SLOT_W] = ns[i];
		end
		for (int j = 0; j < ADDRESS_TAGS; j++) begin
			trow_new[j*TAG_W +: TAG_W] = (SLOT_W'(j) == slot_q) ? tag_q : trow_a[j];
		end
		wb_sat = (32'(wb_sum) > 32'(WB_MAX)) ? WB_MAX : WB_W'(wb_sum);
	end

	assign out_free = !m_valid_q || m_tready;
	assign fin_go   = (state_q == S_FINAL) && out_free;

	assign ram_re     = (state_q == S_READ);
	assign ram_we     = (state_q == S_CLEAR) || fin_go;
	assign ram_waddr  = (state_q == S_CLEAR) ? clr_q : set_q;
	assign trow_wdata = (state_q == S_CLEAR) ? '0 : trow_new;
	assign brow_wdata = (state_q == S_CLEAR) ? '0 : brow_new;

	dsc_ram #(
		.WIDTH (TROW_W),
		.DEPTH (SET_COUNT)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (trow_wdata),
		.re    (ram_re),
		.raddr (set_q),
		.rdata (trow)
	);

	dsc_ram #(
		.WIDTH (BROW_W),
		.DEPTH (SET_COUNT)
	) u_blk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (brow_wdata),
		.re    (ram_re),
		.raddr (set_q),
		.rdata (brow)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			k_q       <= '0;
			m_valid_q <= 1'b0;
			out_q     <= '0;
		end else begin
			m_valid_q <= fin_go || (m_valid_q && !m_tready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SET_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					k_q <= '0;
					if (!hit_c && !tag_eq) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_SCAN: begin
					k_q <= k_q + 1'b1;
					if (k_q == BLK_W'(DATA_BLOCKS - 1)) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_q.pad          <= 1'b0;
						out_q.writebacks   <= wb_sat;
						out_q.tag_replaced <= repl_q;
						out_q.miss_kind    <= kind_q;
						out_q.hit          <= (mode_q == M_HIT);
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working copy of the access and its set
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				wr_q   <= (s_tuser == ACT_WRITE);
				blk_q  <= BLK_W'(blk_r);
				set_q  <= SET_W'(set_r);
				slot_q <= SLOT_W'(slot_r);
				tag_q  <= TAG_W'(addr_m >> SH);
			end
			S_EVAL: begin
				vld_q <= row_vld;
				drt_q <= row_drt;
				for (int i = 0; i < DATA_BLOCKS; i++) begin
					sel_q[i] <= row_sel[i];
				end
				wb_q   <= '0;
				repl_q <= !hit_c && !tag_eq;
				if (hit_c) begin
					mode_q <= M_HIT;
					kind_q <= KIND_HIT;
				end else begin
					kind_q <= any_c ? KIND_MISS_OCC : KIND_MISS_EMPTY;
					if (!row_vld[blk_q] && tag_eq) begin
						mode_q <= M_FILL;
					end else begin
						mode_q <= M_REPL;
					end
				end
			end
			S_SCAN: begin
				if (sel_q[k_q] == slot_q) begin
					wb_q       <= wb_q + WBC_W'(drt_q[k_q]);
					vld_q[k_q] <= 1'b0;
					drt_q[k_q] <= 1'b0;
					sel_q[k_q] <= '0;
				end
			end
			default: begin
				wr_q <= wr_q;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

endmodule

>>> design/dsc_checker.sv
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks for the decoupled sectored cache lookup
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsc_checker
	import dsc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [ADDR_W-1:0]   s_tdata,
	input logic [ACTION_W-1:0] s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [RESULT_W-1:0] m_tdata
);

	result_t res;

	assign res = result_t'(m_tdata);

	`DSC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`DSC_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "request taken while an access is in flight")
	`DSC_ASSERT(a_hit_kind, m_tvalid |-> (res.hit == (res.miss_kind == KIND_HIT)) && (res.miss_kind != KIND_RESERVED), "hit flag and miss kind disagree")
	`DSC_ASSERT(a_hit_clean, m_tvalid && res.hit |-> !res.tag_replaced && (res.writebacks == '0), "hit reported replacement or writeback")
	`DSC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid && !s_tready, "handshake active during reset")

endmodule

bind decoupled_sector_cache_lookup dsc_checker u_dsc_checker (.*);
